// ----- rtl/core/vgpc_pkg.sv -----
// ----------------------------------------------------------------------------
// vgpc_pkg
// Shared types and constants for the voxel grid point counter.
// ----------------------------------------------------------------------------
package vgpc_pkg;

    localparam int GRID_MAX   = 64;
    localparam int CELL_TOTAL = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int ADDR_W     = $clog2(CELL_TOTAL);
    localparam int INDEX_W    = 18;
    localparam int COUNT_W    = 31;
    localparam int GRID_W     = 7;
    localparam int QUOT_W     = 7;
    localparam int PROD_W     = 40;
    localparam int CFG_IDX_W  = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MIN_Y = 3'd1,
        REG_BOX_MIN_Z = 3'd2,
        REG_CUBE_SIZE = 3'd3,
        REG_GRID_SIZE = 3'd4
    } vgpc_reg_t;

    typedef enum logic {
        FUNC_POINT = 1'b0,
        FUNC_READ  = 1'b1
    } vgpc_func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_IDX1,
        ST_IDX2,
        ST_RD,
        ST_WB
    } vgpc_state_t;

    typedef struct packed {
        logic                func;
        logic signed [31:0]  coord_x;
        logic signed [31:0]  coord_y;
        logic signed [31:0]  coord_z;
        logic [INDEX_W-1:0]  cell_address;
    } vgpc_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  cell_index;
        logic [COUNT_W-1:0]  cell_count;
        logic                out_of_box;
    } vgpc_out_t;

endpackage

// ----- rtl/core/voxel_grid_point_counter_top.sv -----
// ----------------------------------------------------------------------------
// voxel_grid_point_counter_top
// Bins points into a cubic voxel grid and keeps a saturating count per cell.
// ----------------------------------------------------------------------------
// After reset the block zeroes its counter memory, one cell per cycle, over
// all 262144 cells; in_stall stays high meanwhile (configuration writes are taken).
// A point then passes through the offset products, the restoring division of
// all three axes side by side with a shared divisor (one quotient bit per cycle),
// the dense index, the counter memory read and write-back, and the idle state
// that takes the next transfer. A point outside the cube goes from the offset
// step straight to write-back; a read item goes through the memory read to
// write-back. Items are processed one at a time; a finished result waits in
// the output register while the next item is taken.
module voxel_grid_point_counter_top
    import vgpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  vgpc_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output vgpc_out_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_data
);

    vgpc_state_t state_reg, state_next;

    logic signed [31:0] min_reg [3];
    logic [31:0]        cube_size_reg;
    logic [GRID_W-1:0]  grid_size_reg;

    logic [31:0]        cube_eff;
    logic [GRID_W-1:0]  grid_eff;

    logic [ADDR_W:0]    clr_reg;
    logic               is_read_reg;
    logic               oob_reg;
    logic [31:0]        coord_reg [3];
    logic [PROD_W-1:0]  rem_reg [3];
    logic [QUOT_W-1:0]  quot_reg [3];
    logic [2:0]         bit_reg;
    logic [12:0]        t1_reg, t2_reg;
    logic [INDEX_W-1:0] idx_reg;

    logic               out_valid_reg;
    vgpc_out_t          out_data_reg;

    logic [COUNT_W-1:0] mem [CELL_TOTAL];
    logic [COUNT_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;

    logic               in_xfer;
    logic               wb_go;
    logic               in_box;
    logic [32:0]        diff [3];
    logic [PROD_W-1:0]  rem_next [3];
    logic [QUOT_W-1:0]  quot_next [3];
    logic [QUOT_W-1:0]  qclamp [3];
    logic [PROD_W-1:0]  dvs;
    logic               addr_ok;
    logic [COUNT_W-1:0] count_next;

    assign cube_eff = (cube_size_reg == 32'd0) ? 32'd1 : cube_size_reg;
    assign grid_eff = (grid_size_reg == '0) ? GRID_W'(1)
                    : (grid_size_reg > GRID_W'(GRID_MAX)) ? GRID_W'(GRID_MAX)
                    : grid_size_reg;

    assign in_xfer = in_valid && !in_stall;
    assign wb_go   = (state_reg == ST_WB) && !(out_valid_reg && out_stall);
    assign addr_ok = ({14'd0, idx_reg} < 32'(CELL_TOTAL));

    // offset, inside test, and one restoring-division step
    always_comb
    begin
        in_box = 1'b1;
        dvs    = PROD_W'(cube_eff) << bit_reg;
        for (int a = 0; a < 3; a++)
        begin
            diff[a] = {coord_reg[a][31], coord_reg[a]} - {min_reg[a][31], min_reg[a]};
            if (diff[a][32] || (diff[a][31:0] > cube_eff))
            begin
                in_box = 1'b0;
            end
            rem_next[a]  = rem_reg[a];
            quot_next[a] = quot_reg[a];
            if (rem_reg[a] >= dvs)
            begin
                rem_next[a]           = rem_reg[a] - dvs;
                quot_next[a][bit_reg] = 1'b1;
            end
            qclamp[a] = (quot_reg[a] > grid_eff - GRID_W'(1)) ? grid_eff - GRID_W'(1)
                      : quot_reg[a];
        end
    end

    always_comb
    begin
        count_next = rd_data_reg;
        if (rd_data_reg != COUNT_MAX)
        begin
            count_next = rd_data_reg + COUNT_W'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == (ADDR_W+1)'(CELL_TOTAL - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (in_data.func == FUNC_READ) ? ST_RD : ST_PREP;
                end
            end
            ST_PREP: state_next = in_box ? ST_DIV : ST_WB;
            ST_DIV:  if (bit_reg == 3'd0) state_next = ST_IDX1;
            ST_IDX1: state_next = ST_IDX2;
            ST_IDX2: state_next = ST_RD;
            ST_RD:   state_next = ST_WB;
            ST_WB:   if (wb_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        cfg_ready = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = clr_reg[ADDR_W-1:0];
        mem_wdata = '0;
        unique case (state_reg)
            ST_CLEAR: mem_we = 1'b1;
            ST_WB:
            begin
                mem_waddr = idx_reg[ADDR_W-1:0];
                mem_wdata = count_next;
                mem_we    = wb_go && !is_read_reg && !oob_reg;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            min_reg[0]    <= '0;
            min_reg[1]    <= '0;
            min_reg[2]    <= '0;
            cube_size_reg <= 32'd1;
            grid_size_reg <= GRID_W'(GRID_MAX);
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + (ADDR_W+1)'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_BOX_MIN_X: min_reg[0]    <= cfg_data;
                    REG_BOX_MIN_Y: min_reg[1]    <= cfg_data;
                    REG_BOX_MIN_Z: min_reg[2]    <= cfg_data;
                    REG_CUBE_SIZE: cube_size_reg <= cfg_data;
                    REG_GRID_SIZE: grid_size_reg <= cfg_data[GRID_W-1:0];
                    default: ;
                endcase
            end
            if (wb_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                is_read_reg  <= (in_data.func == FUNC_READ);
                oob_reg      <= 1'b0;
                coord_reg[0] <= in_data.coord_x;
                coord_reg[1] <= in_data.coord_y;
                coord_reg[2] <= in_data.coord_z;
                idx_reg      <= in_data.cell_address;
            end
            ST_PREP:
            begin
                oob_reg <= !in_box;
                bit_reg <= 3'(QUOT_W - 1);
                for (int a = 0; a < 3; a++)
                begin
                    rem_reg[a]  <= PROD_W'(grid_eff * diff[a][31:0]);
                    quot_reg[a] <= '0;
                end
            end
            ST_DIV:
            begin
                bit_reg <= bit_reg - 3'd1;
                for (int a = 0; a < 3; a++)
                begin
                    rem_reg[a]  <= rem_next[a];
                    quot_reg[a] <= quot_next[a];
                end
            end
            ST_IDX1:
            begin
                t1_reg      <= 13'(qclamp[1] * grid_eff);
                t2_reg      <= 13'(qclamp[2] * grid_eff);
                quot_reg[0] <= qclamp[0];
            end
            ST_IDX2:
            begin
                idx_reg <= INDEX_W'({11'd0, quot_reg[0]}) + INDEX_W'(t1_reg)
                         + INDEX_W'(t2_reg * grid_eff);
            end
            ST_WB:
            begin
                if (wb_go)
                begin
                    if (oob_reg)
                    begin
                        out_data_reg <= '{cell_index: '0, cell_count: '0, out_of_box: 1'b1};
                    end
                    else if (is_read_reg)
                    begin
                        out_data_reg <= '{cell_index: idx_reg,
                                          cell_count: addr_ok ? rd_data_reg : '0,
                                          out_of_box: 1'b0};
                    end
                    else
                    begin
                        out_data_reg <= '{cell_index: idx_reg, cell_count: count_next,
                                          out_of_box: 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> in_stall)
        else $error("input transfer during clearing pass");

    a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_WB))
        else $error("counter write outside write-back");

    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_of_box |-> out_data.cell_count == '0
            && out_data.cell_index == '0)
        else $error("out-of-box result carries data");

    a_wb_result: assert property (@(posedge clk) disable iff (!rst_n)
        wb_go |=> out_valid)
        else $error("write-back produced no result");

endmodule

// ----- tb/tb_voxel_grid_point_counter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_grid_point_counter_top
// Self-checking bench for the voxel grid point counter. Point and read items
// go through a queue-fed driver; a monitor compares each output transfer with
// a predicted cell index, count and out-of-box flag from a local histogram.
// ----------------------------------------------------------------------------
module tb_voxel_grid_point_counter_top;
    import vgpc_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    vgpc_in_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b1;
    vgpc_out_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    voxel_grid_point_counter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // histogram model state
    logic signed [31:0]   min_x, min_y, min_z;
    logic [31:0]          cube_len;
    logic [6:0]           grid_reg;
    logic [COUNT_W-1:0]   hist [CELL_TOTAL];

    vgpc_in_t  pending_items [$];
    vgpc_out_t expected_bins [$];
    int        n_items_sent, n_results, n_mismatch, n_outside, n_reads, n_sat;
    longint    cycle_cnt;
    int        in_gap, out_gap;
    bit        timed_out;

    function automatic int rand_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic void queue_item(vgpc_in_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic bit axis_bin(logic signed [31:0] c, logic signed [31:0] lo,
                                    longint g, longint cube, output longint slot);
        longint d;
        d = longint'(c) - longint'(lo);
        slot = 0;
        if (d < 0 || d > cube)
            return 1'b0;
        slot = (g * d) / cube;
        if (slot > g - 1)
            slot = g - 1;
        return 1'b1;
    endfunction

    function automatic vgpc_out_t bin_item(vgpc_in_t it);
        vgpc_out_t r;
        longint    g, cube, ix, iy, iz, idx;
        bit        okx, oky, okz;
        r = '0;
        if (vgpc_func_t'(it.func) == FUNC_READ) begin
            r.cell_index = it.cell_address;
            r.cell_count = (it.cell_address < CELL_TOTAL) ? hist[it.cell_address] : '0;
            n_reads++;
            return r;
        end
        g = (grid_reg == 0) ? 1 : ((grid_reg > GRID_MAX) ? GRID_MAX : grid_reg);
        cube = (cube_len == 0) ? 1 : longint'(cube_len);
        okx = axis_bin(it.coord_x, min_x, g, cube, ix);
        oky = axis_bin(it.coord_y, min_y, g, cube, iy);
        okz = axis_bin(it.coord_z, min_z, g, cube, iz);
        if (!(okx && oky && okz)) begin
            r.out_of_box = 1'b1;
            n_outside++;
            return r;
        end
        idx = ix + iy * g + iz * g * g;
        if (idx >= CELL_TOTAL)
            idx = CELL_TOTAL - 1;
        if (hist[idx] != COUNT_MAX)
            hist[idx] = hist[idx] + COUNT_W'(1);
        else
            n_sat++;
        r.cell_index = idx[INDEX_W-1:0];
        r.cell_count = hist[idx];
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_bins = {expected_bins, bin_item(in_data)};
                n_items_sent++;
                in_gap = rand_gap();
                if (in_gap == 0 && pending_items.size() != 0)
                begin
                    in_data <= pending_items.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            else if (!in_valid)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (pending_items.size() != 0)
                begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_cnt++;
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (expected_bins.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected transfer: idx %0d cnt %0d oob %0b",
                                 out_data.cell_index, out_data.cell_count,
                                 out_data.out_of_box);
                end
                else
                begin
                    vgpc_out_t e;
                    e = expected_bins.pop_front();
                    if (e.cell_index !== out_data.cell_index
                        || e.cell_count !== out_data.cell_count
                        || e.out_of_box !== out_data.out_of_box)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch #%0d: exp idx %0d cnt %0d oob %0b,",
                                     n_results, e.cell_index, e.cell_count, e.out_of_box,
                                     " got idx %0d cnt %0d oob %0b",
                                     out_data.cell_index, out_data.cell_count,
                                     out_data.out_of_box);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 2) == 0)
                    out_gap = rand_gap();
            end
        end
    end

    task automatic write_reg(vgpc_reg_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BOX_MIN_X: min_x = val;
            REG_BOX_MIN_Y: min_y = val;
            REG_BOX_MIN_Z: min_z = val;
            REG_CUBE_SIZE: cube_len = val;
            REG_GRID_SIZE: grid_reg = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_cube(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                            logic [31:0] cube, logic [6:0] g);
        write_reg(REG_BOX_MIN_X, mx);
        write_reg(REG_BOX_MIN_Y, my);
        write_reg(REG_BOX_MIN_Z, mz);
        write_reg(REG_CUBE_SIZE, cube);
        write_reg(REG_GRID_SIZE, {25'd0, g});
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_bins.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic vgpc_in_t point_item(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        vgpc_in_t it;
        it = '0;
        it.func = FUNC_POINT;
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        it.cell_address = INDEX_W'($urandom());
        return it;
    endfunction

    function automatic vgpc_in_t read_item(logic [INDEX_W-1:0] a);
        vgpc_in_t it;
        it = '0;
        it.func = FUNC_READ;
        it.coord_x = $urandom();
        it.coord_y = $urandom();
        it.coord_z = $urandom();
        it.cell_address = a;
        return it;
    endfunction

    // near-box coordinate: mostly inside, some on faces, some just out
    function automatic logic [31:0] near_coord(logic signed [31:0] lo, logic [31:0] cube);
        longint v;
        case ($urandom_range(0, 9))
            0: v = longint'(lo) - 1;
            1: v = longint'(lo) + longint'(cube) + 1;
            2: v = longint'(lo) + longint'(cube);
            3: v = lo;
            4: v = {$urandom()};
            default: v = longint'(lo) + longint'({$urandom()} % (longint'(cube) + 1));
        endcase
        return v[31:0];
    endfunction

    task automatic random_phase(int n);
        vgpc_in_t it;
        logic [INDEX_W-1:0] a;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                a = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom())
                                                : INDEX_W'($urandom_range(0, 4095));
                it = read_item(a);
            end
            else
                it = point_item(near_coord(min_x, cube_len), near_coord(min_y, cube_len),
                                near_coord(min_z, cube_len));
            queue_item(it);
        end
        wait_drained();
    endtask

    initial
    begin
        min_x = 0; min_y = 0; min_z = 0; cube_len = 1; grid_reg = 64;
        foreach (hist[i]) hist[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset config, extremes, faces, reads
        queue_item(point_item(0, 0, 0));
        queue_item(point_item(1, 1, 1));
        queue_item(point_item(2, 0, 0));
        queue_item(point_item(32'hFFFF_FFFF, 0, 0));
        queue_item(point_item(32'h8000_0000, 32'h7FFF_FFFF, 0));
        queue_item(point_item(1, 1, 1));
        queue_item(read_item(18'h3FFFF));
        queue_item(read_item(0));
        queue_item(read_item(18'h3FFFA));
        wait_drained();

        set_cube(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 7'd64);
        queue_item(point_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        queue_item(point_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        queue_item(point_item(0, 32'h7FFF_FFFF, 32'h8000_0000));
        queue_item(read_item(18'h3FFFF));
        wait_drained();

        set_cube(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 7'd0);
        queue_item(point_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        queue_item(point_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        queue_item(read_item(0));
        wait_drained();

        set_cube(-100, 50, 0, 1000, 7'd127);
        queue_item(point_item(900, 1050, 1000));
        queue_item(point_item(-100, 50, 0));
        queue_item(point_item(899, 1049, 999));
        queue_item(point_item(-101, 50, 0));
        wait_drained();

        // unknown register index is ignored
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= 3'd7;
        cfg_data  <= $urandom();
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;

        // random phases over several settings
        set_cube(-500, 200, -7, 300, 7'd5);
        random_phase(90);
        set_cube(0, 0, 0, 3, 7'd2);
        random_phase(80);
        set_cube($urandom(), $urandom(), $urandom(), $urandom_range(1, 100000), 7'd64);
        random_phase(90);
        set_cube(32'hFFFF_0000, 32'h0000_1234, 32'h8000_0000, 32'h0001_0000, 7'd100);
        random_phase(80);
        set_cube($urandom(), $urandom(), $urandom(), $urandom(), 7'($urandom_range(0, 127)));
        random_phase(80);
        set_cube(10, 20, 30, 63, 7'd1);
        random_phase(80);

        $display("run covered %0d items (%0d reads, %0d out of box, %0d saturated)",
                 n_items_sent, n_reads, n_outside, n_sat);
        $display("%0d results checked, %0d mismatches", n_results, n_mismatch);
        if (n_mismatch == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // timeout: clear pass plus items at worst-case pacing
    initial
    begin
        timed_out = 1'b0;
        wait (cycle_cnt > 64'd1_500_000);
        timed_out = 1'b1;
        $display("timeout after %0d cycles", cycle_cnt);
        $display("status: fail");
        $finish;
    end
endmodule
